FILE: rtl/core/multichannel_biquad_iir_filter_core_assert.svh
// Assertion macros shared by the biquad filter core RTL.
`ifndef MULTICHANNEL_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BIQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/biq_pkg.sv
// Shared constants and types of the biquad filter core.
package biq_pkg;

    // Fixed field widths.
    localparam int COEF_BITS  = 16;
    localparam int CHAN_BITS  = 6;
    localparam int CHAN_COUNT = 1 << CHAN_BITS;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF       = 64;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // The five filter coefficients, Q2.14 two's complement.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

    // Reset leaves the filter as a unity pass-through.
    localparam coef_set_t COEF_RESET = '{
        b0: 16'sd16384,
        b1: 16'sd0,
        b2: 16'sd0,
        a1: 16'sd0,
        a2: 16'sd0
    };

endpackage

FILE: rtl/core/biq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module biq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/biq_regs.sv
// Coefficient registers behind the APB-style configuration port.
module biq_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [biq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [biq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [biq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output biq_pkg::coef_set_t                coefs
);

    import biq_pkg::*;

    coef_set_t             coefs_reg;
    coef_set_t             coefs_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_xfer;
    logic signed [COEF_BITS-1:0] rd_coef;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_xfer = psel && penable && pwrite && pready;

    // Register write decode; writes beyond the last register are dropped.
    always_comb
    begin
        coefs_next = coefs_reg;
        if (wr_xfer)
        begin
            case (reg_idx)
                REG_B0:  coefs_next.b0 = pwdata[COEF_BITS-1:0];
                REG_B1:  coefs_next.b1 = pwdata[COEF_BITS-1:0];
                REG_B2:  coefs_next.b2 = pwdata[COEF_BITS-1:0];
                REG_A1:  coefs_next.a1 = pwdata[COEF_BITS-1:0];
                REG_A2:  coefs_next.a2 = pwdata[COEF_BITS-1:0];
                default: coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= COEF_RESET;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    // Read mux; the coefficient comes back sign-extended.
    always_comb
    begin
        case (reg_idx)
            REG_B0:  rd_coef = coefs_reg.b0;
            REG_B1:  rd_coef = coefs_reg.b1;
            REG_B2:  rd_coef = coefs_reg.b2;
            REG_A1:  rd_coef = coefs_reg.a1;
            REG_A2:  rd_coef = coefs_reg.a2;
            default: rd_coef = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_coef);
    assign coefs  = coefs_reg;

endmodule

FILE: rtl/core/biq_mac.sv
// Two-stage multiply-accumulate with rounding and saturation.
module biq_mac #(
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          prod_en,
    input  biq_pkg::coef_set_t            coefs,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    input  logic signed [SAMPLE_BITS-1:0] x2,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    output logic signed [SAMPLE_BITS-1:0] y,
    output logic                          clip
);

    import biq_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = (PROD_W + 4 > COEF_FRAC_BITS + 2) ? PROD_W + 4
                                                              : COEF_FRAC_BITS + 2;

    localparam logic signed [ACC_W-1:0] ROUND_ONE =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic signed [PROD_W-1:0] p4_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  q_full;
    logic                     clip_hi;
    logic                     clip_lo;

    // First stage: one multiplier per tap, products registered.
    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            p0_reg <= coefs.b0 * x;
            p1_reg <= coefs.b1 * x1;
            p2_reg <= coefs.b2 * x2;
            p3_reg <= coefs.a1 * y1;
            p4_reg <= coefs.a2 * y2;
        end
    end

    // Second stage: exact sum, round to nearest with ties upward, floor shift.
    assign acc = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg)
               - ACC_W'(p3_reg) - ACC_W'(p4_reg) + ROUND_ONE;
    assign q_full = acc >>> COEF_FRAC_BITS;

    // Saturate to the signed sample range and flag it.
    assign clip_hi = (q_full > SAT_MAX);
    assign clip_lo = (q_full < SAT_MIN);
    assign clip    = clip_hi || clip_lo;

    always_comb
    begin
        if (clip_hi)
        begin
            y = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (clip_lo)
        begin
            y = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = q_full[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: rtl/core/multichannel_biquad_iir_filter_core.sv
// Top level of the multichannel Direct Form I biquad filter core.
//
// Usage:
// - Input transfers carry channel, sample_in and track_start on in_valid/in_stall;
//   each produces one output transfer of out_channel, sample_out and clipped on
//   out_valid/out_stall, in the same order.
// - An accepted sample passes stage 1, stage 2 and the output register to reach
//   out_valid. Samples of different channels are taken one per cycle unless
//   stalled. A sample whose channel matches one in stage 1, or held in stage 2,
//   waits, as its feedback term needs that sample's multiply-accumulate output.
// - Per-channel history sits in one RAM read at acceptance and written back as
//   the result enters the output register; the latest write is forwarded.
// - The first sample of every channel must carry track_start = 1; history RAM
//   is not cleared at reset.
// - Reset empties the pipeline, sets b0 = 1.0 and all other coefficients to zero.
//   The user writes coefficients over the APB-style port only while idle; unenforced.
// - When out_stall holds, the output register keeps its transfer, up to three
//   samples stay in flight, and in_stall rises once the pipeline is full.
`include "multichannel_biquad_iir_filter_core_assert.svh"

module multichannel_biquad_iir_filter_core #(
    parameter int CHANNELS       = biq_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [biq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [biq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [biq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [biq_pkg::CHAN_BITS-1:0]     channel,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic                              track_start,
    // Output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [biq_pkg::CHAN_BITS-1:0]     out_channel,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    output logic                              clipped
);

    import biq_pkg::*;

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_W = 4 * SAMPLE_BITS;

    coef_set_t                   coefs;
    logic [IDX_W-1:0]            chan_map [CHAN_COUNT];
    logic [IDX_W-1:0]            in_idx;
    logic                        in_accept;
    logic                        hazard;
    logic                        out_adv;
    logic                        s2_adv;
    logic                        s1_move;
    logic                        s2_leave;

    // Stage 1: sample waiting for its history read
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [CHAN_BITS-1:0]        s1_chan_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic                        s1_start_reg;

    // Stage 2: products registered, history carried for write-back
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic [CHAN_BITS-1:0]        s2_chan_reg;
    logic [IDX_W-1:0]            s2_idx_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x1_reg;
    logic signed [SAMPLE_BITS-1:0] s2_y1_reg;

    // Most recent history write, for forwarding
    logic                        wb_valid_reg;
    logic                        wb_valid_next;
    logic [IDX_W-1:0]            wb_idx_reg;
    logic [HIST_W-1:0]           wb_data_reg;

    // Output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [CHAN_BITS-1:0]        out_chan_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                        out_clip_reg;

    logic [HIST_W-1:0]           ram_rdata;
    logic [HIST_W-1:0]           ram_wdata;
    logic [HIST_W-1:0]           hist_raw;
    logic [HIST_W-1:0]           hist;
    logic signed [SAMPLE_BITS-1:0] h_x1;
    logic signed [SAMPLE_BITS-1:0] h_x2;
    logic signed [SAMPLE_BITS-1:0] h_y1;
    logic signed [SAMPLE_BITS-1:0] h_y2;
    logic signed [SAMPLE_BITS-1:0] mac_y;
    logic                        mac_clip;

    // Configuration registers.
    biq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // Channel number to history entry, wrapping modulo the channel count.
    for (genvar v = 0; v < CHAN_COUNT; v++)
    begin : g_chan_map
        assign chan_map[v] = IDX_W'(v % CHANNELS);
    end

    assign in_idx = chan_map[channel];

    // Pipeline flow control; each stage moves when the one after it has room.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s2_leave = s2_valid_reg && out_adv;
    assign s1_move  = s1_valid_reg && s2_adv;

    // A channel in stage 1, or held in stage 2, blocks a new sample of the same channel.
    assign hazard = (s1_valid_reg && (s1_idx_reg == in_idx))
                 || (s2_valid_reg && (s2_idx_reg == in_idx) && !out_adv);

    assign in_stall  = (s1_valid_reg && !s2_adv) || hazard;
    assign in_accept = in_valid && !in_stall;

    // Valid bits of the stages.
    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !s2_adv);
        s2_valid_next  = s1_move || (s2_valid_reg && !out_adv);
        out_valid_next = s2_valid_reg || (out_valid_reg && out_stall);
        wb_valid_next  = wb_valid_reg || s2_leave;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            wb_valid_reg  <= wb_valid_next;
        end
    end

    // Per-channel history: {x1, x2, y1, y2}.
    biq_ram #(
        .WIDTH (HIST_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (s2_leave),
        .waddr (s2_idx_reg),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // History selection: latest write wins over RAM, start of track reads zero.
    assign hist_raw = (wb_valid_reg && (wb_idx_reg == s1_idx_reg)) ? wb_data_reg : ram_rdata;
    assign hist     = s1_start_reg ? '0 : hist_raw;
    assign h_x1     = hist[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
    assign h_x2     = hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign h_y1     = hist[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign h_y2     = hist[SAMPLE_BITS-1:0];

    // Multiply-accumulate datapath.
    biq_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .prod_en (s1_move),
        .coefs   (coefs),
        .x       (s1_x_reg),
        .x1      (h_x1),
        .x2      (h_x2),
        .y1      (h_y1),
        .y2      (h_y2),
        .y       (mac_y),
        .clip    (mac_clip)
    );

    // Shifted history written back as the result leaves stage 2.
    assign ram_wdata = {s2_x_reg, s2_x1_reg, mac_y, s2_y1_reg};

    // Payload registers of the stages.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_chan_reg  <= channel;
            s1_idx_reg   <= in_idx;
            s1_x_reg     <= sample_in;
            s1_start_reg <= track_start;
        end
        if (s1_move)
        begin
            s2_chan_reg <= s1_chan_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_x_reg    <= s1_x_reg;
            s2_x1_reg   <= h_x1;
            s2_y1_reg   <= h_y1;
        end
        if (s2_leave)
        begin
            wb_idx_reg     <= s2_idx_reg;
            wb_data_reg    <= ram_wdata;
            out_chan_reg   <= s2_chan_reg;
            out_sample_reg <= mac_y;
            out_clip_reg   <= mac_clip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_chan_reg;
    assign sample_out  = out_sample_reg;
    assign clipped     = out_clip_reg;

    // Checks on the interlock and write-back.
    `BIQ_ASSERT_IMPLY(a_no_chan_overlap, clk, rst_n, s1_valid_reg && s2_valid_reg, s1_idx_reg != s2_idx_reg, "two pipeline stages hold the same channel")
    `BIQ_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, s1_valid_reg, "accepted transfer did not reach stage 1")
    `BIQ_ASSERT_NEXT(a_writeback_output, clk, rst_n, s2_valid_reg && out_adv, wb_valid_reg && out_valid_reg, "stage 2 left without write-back and output")

endmodule
